// ===== sv/wsfd_pkg.sv =====
// Shared constants for the websocket frame deframer.
// Holds the result sideband bit layout and the protocol codes.
// No dependencies.
package wsfd_pkg;

  // Opcodes that raise a flag at frame end
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // Header byte 1 decoding
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Byte counts of the extended length and mask key (3-bit count, 8 wraps to 0)
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_BYTES = 3'd0;
  localparam logic [2:0] MASK_BYTES  = 3'd4;

  // Result tuser layout, lowest bit first
  localparam int USER_W      = 8;
  localparam int USER_PVALID = 0;
  localparam int USER_OP_LO  = 1;
  localparam int USER_OP_HI  = 4;
  localparam int USER_PONG   = 5;
  localparam int USER_CLOSE  = 6;
  localparam int USER_IGN    = 7;

endpackage

// ===== sv/websocket_frame_deframer.sv =====
// Websocket frame deframer: one received byte in, one result item out.
// Depends on wsfd_pkg for codes and the tuser layout.
//
// Usage:
//   s_axis carries the received stream, one byte per item in tdata.
//   m_axis gives exactly one result item per input item: tdata is the
//   unmasked payload byte (zero for header bytes), tlast marks the byte
//   that completes a frame, tuser carries payload_valid, the frame opcode,
//   the pong request and close flags and the dropped-after-close flag.
//   The result is registered: a byte accepted at a clock edge has its result
//   loaded into the result register at that edge. Throughput is one byte per
//   cycle while the receiver does not stall; the frame state update and the
//   length counter decrement sit between the frame state registers and the
//   result register. When the receiver stalls, the result register holds
//   and s_axis_tready falls, so at most one result waits. A result may be
//   taken and a new byte accepted in the same cycle.
//   Reset empties the result register and returns the parser to header
//   byte zero with the stream open. After a close frame every byte is
//   answered with the dropped flag until the next reset.
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic       m_axis_tlast,   // frame_end
  output logic [wsfd_pkg::USER_W-1:0] m_axis_tuser
  // [0] payload_valid, [4:1] frame_opcode, [5] send_pong, [6] close_seen, [7] ignored
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT16,
    PH_EXT64,
    PH_MASK,
    PH_PAYLOAD
  } phase_t;

  phase_t                 phase, phase_next;
  logic [2:0]             field_count, field_count_next;
  logic                   mask_present, mask_present_next;
  logic [3:0]             cur_opcode, cur_opcode_next;
  logic [LENGTH_BITS-1:0] length_accum, length_accum_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             mask_index, mask_index_next;
  logic                   stream_closed, stream_closed_next;

  logic       accept;
  logic [2:0] fc_inc;
  logic [7:0] key_byte;
  logic       len_done;
  logic       finish;
  logic       o_pvalid, o_end, o_pong, o_close, o_ign;
  logic [7:0] o_byte;
  logic [3:0] o_opcode;

  // Output register frees up when empty or being taken
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fc_inc        = field_count + 3'd1;

  // Mask key byte for this payload byte, first received byte on top
  always_comb begin
    unique case (mask_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // Frame parser: next state and result fields for one byte
  always_comb begin
    phase_next         = phase;
    field_count_next   = field_count;
    mask_present_next  = mask_present;
    cur_opcode_next    = cur_opcode;
    length_accum_next  = length_accum;
    bytes_left_next    = bytes_left;
    mask_key_next      = mask_key;
    mask_index_next    = mask_index;
    stream_closed_next = stream_closed;
    len_done = 1'b0;
    finish   = 1'b0;
    o_pvalid = 1'b0;
    o_byte   = 8'd0;
    o_end    = 1'b0;
    o_pong   = 1'b0;
    o_close  = 1'b0;
    o_ign    = 1'b0;

    if (stream_closed) begin
      o_ign = 1'b1;
    end else begin
      unique case (phase)
        PH_HDR0: begin
          cur_opcode_next = s_axis_tdata[3:0];
          phase_next      = PH_HDR1;
        end
        PH_HDR1: begin
          mask_present_next = s_axis_tdata[7];
          mask_key_next     = 32'd0;
          mask_index_next   = 2'd0;
          length_accum_next = '0;
          field_count_next  = 3'd0;
          if (s_axis_tdata[6:0] == wsfd_pkg::LEN_EXT16) begin
            phase_next = PH_EXT16;
          end else if (s_axis_tdata[6:0] == wsfd_pkg::LEN_EXT64) begin
            phase_next = PH_EXT64;
          end else begin
            length_accum_next = {{(LENGTH_BITS-7){1'b0}}, s_axis_tdata[6:0]};
            len_done = 1'b1;
          end
        end
        PH_EXT16, PH_EXT64: begin
          // big-endian, high bits beyond the counter width fall off
          length_accum_next = {length_accum[LENGTH_BITS-9:0], s_axis_tdata};
          field_count_next  = fc_inc;
          if (phase == PH_EXT16) begin
            len_done = (fc_inc == wsfd_pkg::EXT16_BYTES);
          end else begin
            len_done = (fc_inc == wsfd_pkg::EXT64_BYTES);
          end
        end
        PH_MASK: begin
          mask_key_next    = {mask_key[23:0], s_axis_tdata};
          field_count_next = fc_inc;
          if (fc_inc == wsfd_pkg::MASK_BYTES) begin
            field_count_next = 3'd0;
            if (length_accum == '0) begin
              finish = 1'b1;
            end else begin
              bytes_left_next = length_accum;
              phase_next      = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          o_pvalid        = 1'b1;
          o_byte          = s_axis_tdata ^ key_byte;
          mask_index_next = mask_index + 2'd1;
          bytes_left_next = bytes_left - LENGTH_BITS'(1);
          finish          = (bytes_left == LENGTH_BITS'(1));
        end
        default: begin
          phase_next       = PH_HDR0;
          field_count_next = 3'd0;
        end
      endcase

      // Length known: mask key, payload or an empty frame
      if (len_done) begin
        field_count_next = 3'd0;
        if (mask_present_next) begin
          phase_next = PH_MASK;
        end else if (length_accum_next == '0) begin
          finish = 1'b1;
        end else begin
          bytes_left_next = length_accum_next;
          phase_next      = PH_PAYLOAD;
        end
      end

      // Frame end flags
      if (finish) begin
        o_end            = 1'b1;
        o_pong           = (cur_opcode == wsfd_pkg::OP_PING);
        o_close          = (cur_opcode == wsfd_pkg::OP_CLOSE);
        stream_closed_next = o_close;
        phase_next       = PH_HDR0;
        field_count_next = 3'd0;
      end
    end

    o_opcode = stream_closed ? 4'd0 : cur_opcode_next;
  end

  // Parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      field_count   <= 3'd0;
      mask_present  <= 1'b0;
      cur_opcode    <= 4'd0;
      length_accum  <= '0;
      bytes_left    <= '0;
      mask_key      <= 32'd0;
      mask_index    <= 2'd0;
      stream_closed <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        field_count   <= field_count_next;
        mask_present  <= mask_present_next;
        cur_opcode    <= cur_opcode_next;
        length_accum  <= length_accum_next;
        bytes_left    <= bytes_left_next;
        mask_key      <= mask_key_next;
        mask_index    <= mask_index_next;
        stream_closed <= stream_closed_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (accept) begin
      m_axis_tdata <= o_byte;
      m_axis_tlast <= o_end;
      m_axis_tuser <= {o_ign, o_close, o_pong, o_opcode, o_pvalid};
    end
  end

endmodule

// ===== sv/wsfd_checker.sv =====
// Port-level checks for the websocket frame deframer, with its bind.
// Depends on wsfd_pkg for the tuser layout and opcodes.
module wsfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [wsfd_pkg::USER_W-1:0] m_axis_tuser
);

  logic [3:0] opcode;
  assign opcode = m_axis_tuser[wsfd_pkg::USER_OP_HI:wsfd_pkg::USER_OP_LO];

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A dropped byte carries nothing else
  a_ignored_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[wsfd_pkg::USER_IGN] |->
      m_axis_tdata == 8'd0 && !m_axis_tlast
      && m_axis_tuser[wsfd_pkg::USER_IGN-1:0] == '0)
    else $error("dropped byte with other fields set");

  // Pong and close flags only at the end of a frame of the matching opcode
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[wsfd_pkg::USER_PONG]
      || m_axis_tuser[wsfd_pkg::USER_CLOSE]) |->
      m_axis_tlast
      && (!m_axis_tuser[wsfd_pkg::USER_PONG] || opcode == wsfd_pkg::OP_PING)
      && (!m_axis_tuser[wsfd_pkg::USER_CLOSE] || opcode == wsfd_pkg::OP_CLOSE))
    else $error("frame flag without matching frame end");

  // Header bytes give a zero data byte
  a_no_payload_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[wsfd_pkg::USER_PVALID] |->
      m_axis_tdata == 8'd0)
    else $error("data byte set on a non-payload item");

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/websocket_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_deframer: framed byte streams go in on
// s_axis, and every m_axis item is checked against a frame parser kept in the bench.
// Depends on wsfd_pkg and the deframer itself.
module websocket_frame_deframer_tb;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 455;
  localparam int HOLD_CYCLES     = 600;
  localparam int TAIL_CYCLES     = 10;

  typedef enum logic [2:0] {
    AT_HDR0, AT_HDR1, AT_EXT16, AT_EXT64, AT_MASK, AT_PAYLOAD
  } parse_phase_t;

  // How a frame encodes its payload length
  typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

  typedef struct packed {
    logic       pvalid;
    logic [7:0] pbyte;
    logic       last;
    logic [3:0] opcode;
    logic       pong;
    logic       close;
    logic       dropped;
  } deframe_result_t;

  // Frame parser plus the queue of results it has worked out
  class deframe_scoreboard;
    parse_phase_t    phase;
    logic [2:0]      field_cnt;
    logic            masked;
    logic [3:0]      opcode;
    logic [63:0]     length;
    logic [63:0]     remaining;
    logic [31:0]     key;
    logic [1:0]      key_idx;
    logic            closed;
    deframe_result_t res;
    deframe_result_t pending_results[$];
    int              errors;

    function new();
      phase     = AT_HDR0;
      field_cnt = '0;
      masked    = 1'b0;
      opcode    = '0;
      length    = '0;
      remaining = '0;
      key       = '0;
      key_idx   = '0;
      closed    = 1'b0;
      errors    = 0;
    endfunction

    function void end_frame();
      res.last = 1'b1;
      if (opcode == wsfd_pkg::OP_PING) res.pong = 1'b1;
      if (opcode == wsfd_pkg::OP_CLOSE) begin
        res.close = 1'b1;
        closed    = 1'b1;
      end
      phase     = AT_HDR0;
      field_cnt = '0;
    endfunction

    // Length complete: mask key next, payload next, or the frame is empty
    function void length_known();
      field_cnt = '0;
      if (masked) phase = AT_MASK;
      else if (length == 0) end_frame();
      else begin
        remaining = length;
        phase     = AT_PAYLOAD;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [2:0] need;
      logic [7:0] kb;
      res = '0;
      if (closed) begin
        res.dropped = 1'b1;
        pending_results = {pending_results, res};
        return;
      end
      unique case (phase)
        AT_HDR0: begin
          opcode = b[3:0];
          phase  = AT_HDR1;
        end
        AT_HDR1: begin
          masked    = b[7];
          key       = '0;
          key_idx   = '0;
          length    = '0;
          field_cnt = '0;
          if (b[6:0] == wsfd_pkg::LEN_EXT16) phase = AT_EXT16;
          else if (b[6:0] == wsfd_pkg::LEN_EXT64) phase = AT_EXT64;
          else begin
            length = 64'(b[6:0]);
            length_known();
          end
        end
        AT_EXT16, AT_EXT64: begin
          // eight length bytes wrap the 3-bit count back to zero
          need      = (phase == AT_EXT16) ? wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES;
          length    = {length[55:0], b};
          field_cnt = field_cnt + 3'd1;
          if (field_cnt == need) length_known();
        end
        AT_MASK: begin
          key       = {key[23:0], b};
          field_cnt = field_cnt + 3'd1;
          if (field_cnt == wsfd_pkg::MASK_BYTES) begin
            field_cnt = '0;
            if (length == 0) end_frame();
            else begin
              remaining = length;
              phase     = AT_PAYLOAD;
            end
          end
        end
        AT_PAYLOAD: begin
          // first key byte sits in the top bits
          kb         = key[24 - 8 * int'(key_idx) +: 8];
          res.pvalid = 1'b1;
          res.pbyte  = b ^ kb;
          key_idx    = key_idx + 2'd1;
          remaining  = remaining - 64'd1;
          if (remaining == 0) end_frame();
        end
        default: begin
          phase     = AT_HDR0;
          field_cnt = '0;
        end
      endcase
      res.opcode = opcode;
      pending_results = {pending_results, res};
    endfunction

    task report(string msg);
      $display("[%0t] error: %s", $time, msg);
      errors++;
    endtask

    task compare(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    task check_result(logic [7:0] data, logic last, logic [wsfd_pkg::USER_W-1:0] user);
      deframe_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected item: tdata %02h tlast %b tuser %02h", data, last, user));
        return;
      end
      want = pending_results.pop_front();
      compare("payload_valid", 8'(user[wsfd_pkg::USER_PVALID]), 8'(want.pvalid));
      compare("payload_byte", data, want.pbyte);
      compare("frame_end", 8'(last), 8'(want.last));
      compare("frame_opcode", 8'(user[wsfd_pkg::USER_OP_HI:wsfd_pkg::USER_OP_LO]),
              8'(want.opcode));
      compare("send_pong", 8'(user[wsfd_pkg::USER_PONG]), 8'(want.pong));
      compare("close_seen", 8'(user[wsfd_pkg::USER_CLOSE]), 8'(want.close));
      compare("ignored", 8'(user[wsfd_pkg::USER_IGN]), 8'(want.dropped));
    endtask
  endclass

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [7:0]                  s_axis_tdata;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [7:0]                  m_axis_tdata;
  logic                        m_axis_tlast;
  logic [wsfd_pkg::USER_W-1:0] m_axis_tuser;

  deframe_scoreboard board = new();
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_left   = 0;
  int bytes_sent  = 0;
  int cycle_count = 0;

  websocket_frame_deframer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // Receiver: long hold-off when asked, otherwise random stalls
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("websocket_frame_deframer: mismatch");
    $finish;
  end

  // One item on s_axis, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    board.note_byte(b);
    bytes_sent++;
  endtask

  task automatic drive_frame(input logic [7:0] hdr0, input logic masked, input logic [63:0] len,
                             input len_form_t form, input logic [31:0] key);
    logic [6:0] short_len;
    unique case (form)
      FORM_EXT16: short_len = wsfd_pkg::LEN_EXT16;
      FORM_EXT64: short_len = wsfd_pkg::LEN_EXT64;
      default:    short_len = len[6:0];
    endcase
    send_byte(hdr0);
    send_byte({masked, short_len});
    if (form == FORM_EXT16) for (int i = 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (form == FORM_EXT64) for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (masked) for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    for (longint n = 0; n < len; n++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Any opcode but close; mostly short payloads, a few long ones
  task automatic send_random_frame();
    logic [3:0]  op;
    logic [7:0]  hdr1;
    logic [63:0] len;
    len_form_t   form;
    int          pick;
    do op = 4'($urandom_range(0, 15)); while (op == wsfd_pkg::OP_CLOSE);
    hdr1 = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    form = FORM_SHORT;
    if (pick < 55) len = 64'($urandom_range(0, 12));
    else if (pick < 62) len = 64'($urandom_range(0, 125));
    else if (pick < 80) begin
      form = FORM_EXT16;
      len  = 64'($urandom_range(0, 24));
    end else if (pick < 83) begin
      form = FORM_EXT16;
      len  = 64'($urandom_range(200, 300));
    end else if (pick < 95) begin
      form = FORM_EXT64;
      len  = 64'($urandom_range(0, 20));
    end else begin
      // header byte 1 taken as drawn, long forms kept short
      if (hdr1[6:0] == wsfd_pkg::LEN_EXT16) begin
        form = FORM_EXT16;
        len  = 64'($urandom_range(0, 40));
      end else if (hdr1[6:0] == wsfd_pkg::LEN_EXT64) begin
        form = FORM_EXT64;
        len  = 64'($urandom_range(0, 40));
      end else begin
        len = 64'(hdr1[6:0]);
      end
    end
    drive_frame({4'($urandom_range(0, 15)), op}, hdr1[7], len, form, $urandom);
  endtask

  initial begin
    int target;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames
    // ping with one unmasked payload byte
    drive_frame({4'h8, wsfd_pkg::OP_PING}, 1'b0, 64'd1, FORM_SHORT, '0);
    // all-ones header byte 0, empty masked frame: ends on the last key byte
    drive_frame(8'hff, 1'b1, 64'd0, FORM_SHORT, 32'h00ff_00ff);
    // empty frame in the 8-byte form: ends on the last length byte
    drive_frame(8'h00, 1'b0, 64'd0, FORM_EXT64, '0);
    // non-minimal 2-byte length with an all-ones key
    drive_frame(8'h82, 1'b1, 64'd2, FORM_EXT16, 32'hffff_ffff);
    // empty unmasked frame: ends on header byte 1
    drive_frame(8'h0a, 1'b0, 64'd0, FORM_SHORT, '0);

    // Random frames under each idling mix; the first opens with a long receiver hold
    for (int ph = 0; ph < 4; ph++) begin
      unique case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_left = HOLD_CYCLES;
        end
        1: begin
          idle_pct  = 75;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 75;
        end
        default: begin
          idle_pct  = 27;
          stall_pct = 27;
        end
      endcase
      target = bytes_sent + ITEMS_PER_PHASE;
      while (bytes_sent < target) send_random_frame();
    end

    // Close frame, then bytes that must be dropped
    drive_frame({4'h8, wsfd_pkg::OP_CLOSE}, 1'b1, 64'd3, FORM_SHORT, $urandom);
    repeat (6) send_byte(8'($urandom_range(0, 255)));

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) $display("websocket_frame_deframer: match");
    else $display("websocket_frame_deframer: mismatch");
    $finish;
  end

endmodule
